### rtl/rcfd_pkg.sv
// shared constants and the crc-8 byte update of the frame decoder
package rcfd_pkg;

    localparam int RAW_W    = 12;
    localparam int GAIN_W   = 17;
    localparam int VALUE_W  = 16;
    localparam int PROD_W   = RAW_W + GAIN_W;
    localparam int SUM_W    = 32;

    localparam logic [SUM_W-1:0] ROUND_HALF = 32'h0000_8000;
    localparam logic [7:0]       CRC_POLY   = 8'h07;

    // configuration register indexes
    localparam logic [2:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [2:0] CFG_TYPE_12     = 3'd2;
    localparam logic [2:0] CFG_TYPE_24     = 3'd3;
    localparam logic [2:0] CFG_GAIN        = 3'd4;
    localparam logic [2:0] CFG_OFFSET      = 3'd5;
    localparam logic [2:0] CFG_DROP_LIMIT  = 3'd6;

    // crc-8, msb first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/rcfd_scale.sv
// channel scaler: registered raw times gain, then rounding shift and offset
module rcfd_scale
(
    input  logic                            clk,
    input  logic                            mul_en,
    input  logic [rcfd_pkg::RAW_W-1:0]      raw,
    input  logic [rcfd_pkg::GAIN_W-1:0]     gain,
    input  logic [rcfd_pkg::VALUE_W-1:0]    offset,
    output logic [rcfd_pkg::VALUE_W-1:0]    value
);

    logic [rcfd_pkg::PROD_W-1:0] prod_reg;
    logic [rcfd_pkg::SUM_W-1:0]  rounded;

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= rcfd_pkg::PROD_W'(raw) * rcfd_pkg::PROD_W'(gain);
    end

    // round at bit 15, keep 16 bits, add offset with wrap
    assign rounded = rcfd_pkg::SUM_W'(prod_reg) + rcfd_pkg::ROUND_HALF;
    assign value   = rounded[31:16] + offset;

endmodule

### rtl/rc_frame_decoder_crc8.sv
// top level of the radio-control serial frame decoder with crc-8 check
//
// channel   dir   contents
// s_*       in    received byte (tdata), rate flag (tuser)
// m_*       out   channel number, scaled value, rssi (tdata), failsafe (tuser), last (tlast)
// cfg_*     in    register writes, no read-back
//
// one received byte is taken per cycle while a frame is being received
// after a good channel frame the byte input is held off while channels are read back
//   from the payload memory: rssi and count first, then for each channel pair three
//   reads, then multiply and load for each channel, set by the single memory read
//   port and the multiply register
// a load waits while the output register holds an item the sink has not taken
// reset puts the decoder in sync hunt; the payload memory is not cleared
module rc_frame_decoder_crc8
#(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int MAX_CHANNELS    = 18,
    parameter int RSSI_POS        = 2,
    parameter int COUNT_POS       = 3,
    parameter int CHAN_START      = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [0:0]  s_tuser,   // rate_ok[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // channel_number[4:0], channel_value[20:5], signal_strength[28:21]
    output logic [0:0]  m_tuser,   // failsafe[0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int AW      = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_MAX = MAX_FRAME_BYTES + 2;
    localparam int N12     = (MAX_CHANNELS < 12) ? MAX_CHANNELS : 12;
    localparam int N24     = (MAX_CHANNELS < 24) ? MAX_CHANNELS : 24;

    typedef enum logic [3:0]
    {
        S_HUNT, S_SYNC1, S_SYNC2, S_LEN, S_PAYLOAD, S_CRC,
        E_RSSI, E_COUNT, E_B0, E_B1, E_B2, E_MUL, E_OUT
    } state_t;

    // configuration
    logic [7:0]  sync_first_reg, sync_second_reg, type_12_reg, type_24_reg, drop_limit_reg;
    logic [16:0] gain_reg;
    logic [15:0] offset_reg;

    // frame control
    state_t      state_reg;
    logic [7:0]  frame_length_reg, bytes_seen_reg, frame_type_reg, crc_reg;
    logic [4:0]  n_reg, chan_reg;
    logic [7:0]  base_reg;

    // readback payload
    logic [7:0]  rssi_reg, b0_reg, b1_reg;
    logic        fs_reg;

    // output register
    logic        m_tvalid_reg, m_tlast_reg, m_fs_reg;
    logic [4:0]  m_num_reg;
    logic [15:0] m_value_reg;
    logic [7:0]  m_rssi_reg;

    // payload memory
    logic [7:0]  mem [MAX_FRAME_BYTES];
    logic [7:0]  rd_data_reg;
    logic        rd_oob_reg;

    logic        in_take, byte_ok, emitting, out_free, out_load, mul_en, rd_en, rd_oob, wr_en;
    logic [7:0]  in_byte, rd_addr, wr_idx, rd_byte, crc_in, seen_inc;
    logic [11:0] raw;
    logic [15:0] scaled;

    assign in_byte  = s_tdata;
    assign in_take  = s_tvalid && s_tready;
    assign byte_ok  = in_take && s_tuser[0];
    assign crc_in   = rcfd_pkg::crc8_byte(crc_reg, in_byte);
    assign seen_inc = bytes_seen_reg + 8'd1;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        emitting = state_reg inside {E_RSSI, E_COUNT, E_B0, E_B1, E_B2, E_MUL, E_OUT};
    end

    assign s_tready = !emitting;
    assign out_load = (state_reg == E_OUT) && out_free;
    assign mul_en   = (state_reg == E_MUL);

    // payload write while receiving the frame body
    assign wr_idx = bytes_seen_reg - 8'd1;
    assign wr_en  = byte_ok && (state_reg == S_PAYLOAD) && (int'(wr_idx) < MAX_FRAME_BYTES);

    // read address for the readback sequence
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = base_reg;
        case (state_reg)
            E_RSSI:  rd_addr = 8'(RSSI_POS);
            E_COUNT: rd_addr = 8'(COUNT_POS);
            E_B0:    rd_addr = base_reg;
            E_B1:    rd_addr = base_reg + 8'd1;
            E_B2:    rd_addr = base_reg + 8'd2;
            default: rd_en = 1'b0;
        endcase
    end

    assign rd_oob  = int'(rd_addr) >= MAX_FRAME_BYTES;
    assign rd_byte = rd_oob_reg ? 8'd0 : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx[AW-1:0]] <= in_byte;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
            rd_oob_reg  <= rd_oob;
        end
    end

    // even channel from b0 and high nibble of b1, odd from low nibble of b1 and b2
    assign raw = chan_reg[0] ? {b1_reg[3:0], rd_byte} : {b0_reg, b1_reg[7:4]};

    rcfd_scale u_scale
    (
        .clk    (clk),
        .mul_en (mul_en),
        .raw    (raw),
        .gain   (gain_reg),
        .offset (offset_reg),
        .value  (scaled)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'h55;
            sync_second_reg <= 8'h55;
            type_12_reg     <= 8'd0;
            type_24_reg     <= 8'd1;
            gain_reg        <= 17'd17476;
            offset_reg      <= 16'd967;
            drop_limit_reg  <= 8'd255;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rcfd_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                rcfd_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                rcfd_pkg::CFG_TYPE_12:     type_12_reg     <= cfg_data[7:0];
                rcfd_pkg::CFG_TYPE_24:     type_24_reg     <= cfg_data[7:0];
                rcfd_pkg::CFG_GAIN:        gain_reg        <= cfg_data;
                rcfd_pkg::CFG_OFFSET:      offset_reg      <= cfg_data[15:0];
                rcfd_pkg::CFG_DROP_LIMIT:  drop_limit_reg  <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    // frame receive and readback sequencer, with the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_HUNT;
            frame_length_reg <= 8'd0;
            bytes_seen_reg   <= 8'd0;
            frame_type_reg   <= 8'd0;
            crc_reg          <= 8'd0;
            n_reg            <= 5'd0;
            chan_reg         <= 5'd0;
            base_reg         <= 8'd0;
            rssi_reg         <= 8'd0;
            b0_reg           <= 8'd0;
            b1_reg           <= 8'd0;
            fs_reg           <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_num_reg        <= 5'd0;
            m_value_reg      <= 16'd0;
            m_rssi_reg       <= 8'd0;
            m_fs_reg         <= 1'b0;
            m_tlast_reg      <= 1'b0;
        end
        else
        begin
            // output valid: set on a load, cleared once the sink takes the item
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_HUNT:
                begin
                    if (byte_ok && (in_byte == sync_first_reg))
                        state_reg <= S_SYNC1;
                end
                S_SYNC1:
                begin
                    if (byte_ok)
                        state_reg <= (in_byte == sync_second_reg) ? S_SYNC2 : S_HUNT;
                end
                S_SYNC2:
                begin
                    if (byte_ok)
                    begin
                        if ((in_byte > 8'd8) && (int'(in_byte) <= LEN_MAX))
                        begin
                            frame_length_reg <= in_byte;
                            bytes_seen_reg   <= 8'd0;
                            crc_reg          <= rcfd_pkg::crc8_byte(8'd0, in_byte);
                            state_reg        <= S_LEN;
                        end
                        else
                            state_reg <= S_HUNT;
                    end
                end
                S_LEN:
                begin
                    if (byte_ok)
                    begin
                        frame_type_reg <= in_byte;
                        bytes_seen_reg <= 8'd1;
                        crc_reg        <= crc_in;
                        state_reg      <= S_PAYLOAD;
                    end
                end
                S_PAYLOAD:
                begin
                    if (byte_ok)
                    begin
                        bytes_seen_reg <= seen_inc;
                        crc_reg        <= crc_in;
                        if (seen_inc == frame_length_reg - 8'd1)
                            state_reg <= S_CRC;
                    end
                end
                S_CRC:
                begin
                    if (byte_ok)
                    begin
                        bytes_seen_reg <= seen_inc;
                        chan_reg       <= 5'd0;
                        base_reg       <= 8'(CHAN_START);
                        // twelve-channel code wins when both codes are equal
                        if ((crc_reg == in_byte) && (frame_type_reg == type_12_reg))
                        begin
                            n_reg     <= 5'(N12);
                            state_reg <= E_RSSI;
                        end
                        else if ((crc_reg == in_byte) && (frame_type_reg == type_24_reg))
                        begin
                            n_reg     <= 5'(N24);
                            state_reg <= E_RSSI;
                        end
                        else
                            state_reg <= S_HUNT;
                    end
                end
                E_RSSI:
                    state_reg <= E_COUNT;
                E_COUNT:
                begin
                    rssi_reg  <= rd_byte;
                    state_reg <= E_B0;
                end
                E_B0:
                begin
                    if (chan_reg == 5'd0)
                        fs_reg <= rd_byte > drop_limit_reg;
                    state_reg <= E_B1;
                end
                E_B1:
                begin
                    b0_reg    <= rd_byte;
                    state_reg <= E_B2;
                end
                E_B2:
                begin
                    b1_reg    <= rd_byte;
                    state_reg <= E_MUL;
                end
                E_MUL:
                    state_reg <= E_OUT;
                E_OUT:
                begin
                    if (out_free)
                    begin
                        m_num_reg    <= chan_reg;
                        m_value_reg  <= scaled;
                        m_rssi_reg   <= rssi_reg;
                        m_fs_reg     <= fs_reg;
                        m_tlast_reg  <= (chan_reg + 5'd1 == n_reg);
                        chan_reg     <= chan_reg + 5'd1;
                        if (chan_reg + 5'd1 == n_reg)
                            state_reg <= S_HUNT;
                        else if (!chan_reg[0])
                            state_reg <= E_MUL;
                        else
                        begin
                            base_reg  <= base_reg + 8'd3;
                            state_reg <= E_B0;
                        end
                    end
                end
                default:
                    state_reg <= S_HUNT;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_rssi_reg, m_value_reg, m_num_reg};
    assign m_tuser  = m_fs_reg;
    assign m_tlast  = m_tlast_reg;

    // readback never runs past the channel count of the frame
    a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitting |-> (chan_reg < n_reg))
        else $error("channel index past frame channel count");

    // readback only starts from a checked crc byte
    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(emitting) |-> ($past(state_reg) == S_CRC) && $past(byte_ok))
        else $error("readback started without a crc byte");

    // no payload write can land while the memory is being read back
    a_no_write_in_readback: assert property (@(posedge clk) disable iff (!rst_n)
        emitting |-> !wr_en)
        else $error("payload write during readback");

    // body bytes only arrive for an accepted length
    a_len_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAYLOAD) |-> (frame_length_reg > 8'd8) &&
                                     (bytes_seen_reg < frame_length_reg))
        else $error("payload state with bad length bookkeeping");

endmodule

### dv/rc_frame_decoder_crc8_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the crc-8 radio-control frame decoder
module rc_frame_decoder_crc8_tb;

    // block geometry, kept equal to the instance parameters below
    localparam int MAX_FRAME_BYTES = 64;
    localparam int MAX_CHANNELS    = 18;
    localparam int RSSI_POS        = 2;
    localparam int COUNT_POS       = 3;
    localparam int CHAN_START      = 4;

    localparam logic [7:0] CRC8_POLY = 8'h07;
    localparam int MIN_FRAME_LEN  = 9;                    // length byte must exceed 8
    localparam int MAX_FRAME_LEN  = MAX_FRAME_BYTES + 2;
    // shortest frame whose payload covers every store entry readback can reach
    localparam int COVER_LEN      = CHAN_START + 3 * ((MAX_CHANNELS + 1) / 2) + 2;
    localparam int TWELVE_CAP     = 12;
    localparam int TWENTYFOUR_CAP = 24;

    // settle wait after the last channel is out, to cover any tail of work
    localparam int SETTLE_CYCLES  = 32;
    // longest quiet stretch of a good run is the longest sink stall on top of a readout
    // step, or the settle wait; this is many times that
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // where the receiver stands within a frame
    typedef enum int {
        HUNT_FIRST,
        HUNT_SECOND,
        WANT_LENGTH,
        WANT_TYPE,
        IN_PAYLOAD,
        WANT_CRC
    } rx_phase_e;

    typedef struct {
        logic [4:0]  number;
        logic [15:0] value;
        logic [7:0]  rssi;
        logic        fs;
        logic        last;
    } channel_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // data_byte[7:0]
    logic [0:0]  s_tuser;     // rate_ok[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // channel_number[4:0], channel_value[20:5], signal_strength[28:21]
    logic [0:0]  m_tuser;     // failsafe[0]
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // register copies for the decoder model
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [7:0]  code12;
    logic [7:0]  code24;
    logic [16:0] gain_q16;
    logic [15:0] offset16;
    logic [7:0]  drop_lim;

    // receiver state of the decoder model
    rx_phase_e   rx_phase;
    logic [7:0]  frame_len;
    logic [7:0]  byte_count;
    logic [7:0]  frame_kind;
    logic [7:0]  crc_acc;
    logic [7:0]  frame_bytes [0:MAX_FRAME_BYTES-1];

    // payload of the next frame to send
    logic [7:0]  pay_buf [0:MAX_FRAME_BYTES-1];

    channel_item_t pending_channels[$];
    channel_item_t want;

    int bytes_taken;
    int channels_predicted;
    int results_seen;
    int frames_sent;
    int mismatches;
    int src_gap_pct;
    int sink_stall_pct;
    int noise_pct;
    int sink_hold;
    int quiet_cycles;

    rc_frame_decoder_crc8
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MAX_CHANNELS    (MAX_CHANNELS),
        .RSSI_POS        (RSSI_POS),
        .COUNT_POS       (COUNT_POS),
        .CHAN_START      (CHAN_START)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------

    // serial lfsr form of crc-8, data bits fed msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    // payload store read, zero past the end
    function automatic logic [7:0] stored(input int idx);
        return (idx < MAX_FRAME_BYTES) ? frame_bytes[idx] : 8'h00;
    endfunction

    // q16 gain with rounding, then the offset, both wrapping at 16 bits
    function automatic logic [15:0] scale_channel(input logic [11:0] raw);
        logic [31:0] prod;
        prod = {20'd0, raw} * {15'd0, gain_q16} + 32'h0000_8000;
        return prod[31:16] + offset16;
    endfunction

    // queue one expected item per channel of a good frame
    function automatic void unpack_channels(input int cap);
        int            n;
        int            base;
        logic [7:0]    b0;
        logic [7:0]    b1;
        logic [7:0]    b2;
        logic [11:0]   raw;
        channel_item_t c;
        n = (cap < MAX_CHANNELS) ? cap : MAX_CHANNELS;
        for (int k = 0; k < n; k++)
        begin
            // two 12-bit channels share each 3-byte group
            base = CHAN_START + 3 * (k / 2);
            b0   = stored(base);
            b1   = stored(base + 1);
            b2   = stored(base + 2);
            raw  = (k % 2) ? {b1[3:0], b2} : {b0, b1[7:4]};
            c.number = 5'(k);
            c.value  = scale_channel(raw);
            c.rssi   = stored(RSSI_POS);
            c.fs     = stored(COUNT_POS) > drop_lim;
            c.last   = (k == n - 1);
            pending_channels.push_back(c);
            channels_predicted++;
        end
    endfunction

    // advance the model by one accepted byte
    function automatic void track_byte(input logic [7:0] b, input logic ok);
        int idx;
        if (ok)
        begin
            case (rx_phase)
                HUNT_FIRST:
                    if (b == sync_a)
                        rx_phase = HUNT_SECOND;
                HUNT_SECOND:
                    rx_phase = (b == sync_b) ? WANT_LENGTH : HUNT_FIRST;
                WANT_LENGTH:
                    // length outside 9..66 drops back to the hunt
                    if (b >= MIN_FRAME_LEN && b <= MAX_FRAME_LEN)
                    begin
                        frame_len  = b;
                        byte_count = 8'd0;
                        crc_acc    = crc8_step(8'h00, b);
                        rx_phase   = WANT_TYPE;
                    end
                    else
                        rx_phase = HUNT_FIRST;
                WANT_TYPE:
                begin
                    frame_kind = b;
                    byte_count = 8'd1;
                    crc_acc    = crc8_step(crc_acc, b);
                    rx_phase   = IN_PAYLOAD;
                end
                IN_PAYLOAD:
                begin
                    idx = int'(byte_count) - 1;
                    if (idx < MAX_FRAME_BYTES)
                        frame_bytes[idx] = b;
                    byte_count = byte_count + 8'd1;
                    crc_acc    = crc8_step(crc_acc, b);
                    if (byte_count == frame_len - 8'd1)
                        rx_phase = WANT_CRC;
                end
                WANT_CRC:
                begin
                    // equal type codes fall into the twelve-channel branch
                    if (crc_acc == b)
                    begin
                        if (frame_kind == code12)
                            unpack_channels(TWELVE_CAP);
                        else if (frame_kind == code24)
                            unpack_channels(TWENTYFOUR_CAP);
                    end
                    rx_phase = HUNT_FIRST;
                end
                default:
                    rx_phase = HUNT_FIRST;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: stalls, checking, watchdog
    // ------------------------------------------------------------------

    // sink stalls in bursts of random length
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            sink_hold = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each result item with the oldest expected channel
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_channels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected item ch %0d value %h rssi %h fs %b last %b",
                             $realtime, m_tdata[4:0], m_tdata[20:5], m_tdata[28:21],
                             m_tuser[0], m_tlast);
            end
            else
            begin
                want = pending_channels.pop_front();
                results_seen++;
                if (m_tdata[4:0] !== want.number || m_tdata[20:5] !== want.value ||
                    m_tdata[28:21] !== want.rssi || m_tdata[31:29] !== 3'b000 ||
                    m_tuser[0] !== want.fs || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: expected ch %0d value %h rssi %h fs %b last %b",
                                 $realtime, want.number, want.value, want.rssi, want.fs,
                                 want.last);
                        $display("%0t: got ch %0d value %h rssi %h fs %b last %b pad %b",
                                 $realtime, m_tdata[4:0], m_tdata[20:5], m_tdata[28:21],
                                 m_tuser[0], m_tlast, m_tdata[31:29]);
                    end
                end
            end
        end
    end

    // ends a run in which nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d channels outstanding",
                         quiet_cycles, pending_channels.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one byte across the input handshake, with an occasional source gap
    task automatic send_byte(input logic [7:0] b, input logic ok);
        if ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= ok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_byte(b, ok);
        if (ok)
            bytes_taken++;
    endtask

    // a byte at the right rate, sometimes preceded by an off-rate byte
    task automatic send_good(input logic [7:0] b);
        if ($urandom_range(0, 99) < noise_pct)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(b, 1'b1);
    endtask

    // random payload, or every byte set to one value
    task automatic fill_payload(input logic [7:0] fixed, input bit scramble);
        for (int i = 0; i < MAX_FRAME_BYTES; i++)
            pay_buf[i] = scramble ? 8'($urandom_range(0, 255)) : fixed;
    endtask

    // sync, length, type, payload from pay_buf and a good or corrupted crc
    task automatic send_frame(input logic [7:0] kind, input int len, input bit crc_ok);
        logic [7:0] crc;
        crc = crc8_step(8'h00, len[7:0]);
        crc = crc8_step(crc, kind);
        for (int i = 0; i < len - 2; i++)
            crc = crc8_step(crc, pay_buf[i]);
        if (!crc_ok)
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        send_good(sync_a);
        send_good(sync_b);
        send_good(len[7:0]);
        send_good(kind);
        for (int i = 0; i < len - 2; i++)
            send_good(pay_buf[i]);
        send_good(crc);
        frames_sent++;
    endtask

    // finish any open frame, then hold the source until all channels are out
    task automatic go_idle();
        while (rx_phase != HUNT_FIRST)
            send_byte(8'h00, 1'b1);
        s_tvalid <= 1'b0;
        while (pending_channels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            rcfd_pkg::CFG_SYNC_FIRST:  sync_a   = val[7:0];
            rcfd_pkg::CFG_SYNC_SECOND: sync_b   = val[7:0];
            rcfd_pkg::CFG_TYPE_12:     code12   = val[7:0];
            rcfd_pkg::CFG_TYPE_24:     code24   = val[7:0];
            rcfd_pkg::CFG_GAIN:        gain_q16 = val;
            rcfd_pkg::CFG_OFFSET:      offset16 = val[15:0];
            rcfd_pkg::CFG_DROP_LIMIT:  drop_lim = val[7:0];
            default:                   ;
        endcase
    endtask

    // writes every register back to back, only while the decoder is idle
    task automatic apply_settings(input logic [7:0] first_sync, input logic [7:0] second_sync,
                                  input logic [7:0] twelve_code, input logic [7:0] twentyfour_code,
                                  input logic [16:0] gain, input logic [15:0] offset,
                                  input logic [7:0] limit);
        write_reg(rcfd_pkg::CFG_SYNC_FIRST, {9'd0, first_sync});
        write_reg(rcfd_pkg::CFG_SYNC_SECOND, {9'd0, second_sync});
        write_reg(rcfd_pkg::CFG_TYPE_12, {9'd0, twelve_code});
        write_reg(rcfd_pkg::CFG_TYPE_24, {9'd0, twentyfour_code});
        write_reg(rcfd_pkg::CFG_GAIN, gain);
        write_reg(rcfd_pkg::CFG_OFFSET, {1'b0, offset});
        write_reg(rcfd_pkg::CFG_DROP_LIMIT, {9'd0, limit});
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values; the first frame writes every store entry that
    // channel readback can reach, so nothing unwritten is ever read back
    task automatic test_reset_settings();
        src_gap_pct = 20;
        noise_pct   = 0;
        fill_payload(8'h00, 1'b1);
        send_frame(code24, COVER_LEN, 1'b1);
        go_idle();
    endtask

    // largest gain with the most negative offset, then zero gain
    task automatic test_scale_extremes();
        apply_settings(8'h55, 8'h55, 8'h00, 8'h01, 17'h1FFFF, 16'h8000, 8'h00);
        fill_payload(8'hFF, 1'b0);
        pay_buf[COUNT_POS] = 8'h01;                 // just over a zero limit
        send_frame(code24, MIN_FRAME_LEN, 1'b1);
        go_idle();
        // sync bytes at both ends of the byte range
        apply_settings(8'hFF, 8'h00, 8'h7E, 8'h81, 17'h00000, 16'h7FFF, 8'hFE);
        fill_payload(8'h00, 1'b0);
        pay_buf[COUNT_POS] = 8'hFE;                 // count equal to the limit, clear
        send_frame(code12, MIN_FRAME_LEN, 1'b1);
        go_idle();
    endtask

    // frames that must give nothing, mixed with off-rate bytes
    task automatic test_dropped_frames();
        apply_settings(8'h55, 8'h55, 8'h00, 8'h01, 17'd17476, 16'd967, 8'd200);
        src_gap_pct = 30;
        noise_pct   = 15;
        fill_payload(8'h00, 1'b1);
        send_frame(code24, MIN_FRAME_LEN, 1'b0);    // corrupted crc
        send_frame(8'h42, MIN_FRAME_LEN, 1'b1);     // unknown type
        // length one below the minimum, then one above the maximum
        send_good(sync_a);
        send_good(sync_b);
        send_good(8'(MIN_FRAME_LEN - 1));
        send_good(sync_a);
        send_good(sync_b);
        send_good(8'(MAX_FRAME_LEN + 1));
        // second sync wrong
        send_good(sync_a);
        send_good(8'h12);
        go_idle();
    endtask

    // both type codes equal: the frame is treated as twelve channels
    task automatic test_equal_type_codes();
        apply_settings(8'hA5, 8'h5A, 8'hC3, 8'hC3, 17'd65536, 16'd0, 8'd128);
        fill_payload(8'h00, 1'b1);
        send_frame(8'hC3, MIN_FRAME_LEN + 3, 1'b1);
        go_idle();
    endtask

    // mostly well-formed frames with random content, plus noise and broken syncs
    task automatic test_random_traffic(input int byte_goal, input int channel_goal);
        int         first_byte;
        int         first_channel;
        int         pick;
        int         len;
        logic [7:0] kind;
        logic [7:0] flip;
        first_byte    = bytes_taken;
        first_channel = channels_predicted;
        while (bytes_taken - first_byte < byte_goal ||
               channels_predicted - first_channel < channel_goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                // short frames mostly, sometimes longer
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_FRAME_LEN, COVER_LEN)
                                                  : $urandom_range(MIN_FRAME_LEN, 14);
                case ($urandom_range(0, 3))
                    0:       kind = code12;
                    1, 2:    kind = code24;
                    default: kind = 8'($urandom_range(0, 255));
                endcase
                fill_payload(8'h00, 1'b1);
                send_frame(kind, len, $urandom_range(0, 9) != 0);
            end
            else if (pick == 7)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (pick == 8)
            begin
                send_good(sync_a);
                send_good(sync_b);
                send_good($urandom_range(0, 1) ? 8'($urandom_range(0, MIN_FRAME_LEN - 1))
                                               : 8'($urandom_range(MAX_FRAME_LEN + 1, 255)));
            end
            else
            begin
                flip = 8'($urandom_range(1, 255));
                send_good(sync_a);
                send_good(sync_b ^ flip);
            end
        end
        go_idle();
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= rcfd_pkg::CFG_SYNC_FIRST;
        cfg_data  <= 17'd0;

        // model starts from the reset register values
        sync_a   = 8'h55;
        sync_b   = 8'h55;
        code12   = 8'h00;
        code24   = 8'h01;
        gain_q16 = 17'd17476;
        offset16 = 16'd967;
        drop_lim = 8'd255;
        rx_phase   = HUNT_FIRST;
        frame_len  = 8'd0;
        byte_count = 8'd0;
        frame_kind = 8'd0;
        crc_acc    = 8'd0;
        for (int i = 0; i < MAX_FRAME_BYTES; i++)
            frame_bytes[i] = 8'h00;

        bytes_taken        = 0;
        channels_predicted = 0;
        results_seen       = 0;
        frames_sent        = 0;
        mismatches         = 0;
        sink_hold          = 0;
        quiet_cycles       = 0;
        src_gap_pct        = 0;
        sink_stall_pct     = 0;
        noise_pct          = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sink_stall_pct = 25;
        test_reset_settings();
        test_scale_extremes();
        test_dropped_frames();

        // random settings with idling on both sides
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        noise_pct      = 10;
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       17'($urandom_range(0, 131071)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)));
        test_random_traffic(10, 0);

        // no idling at all in the last part
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        noise_pct      = 0;
        test_equal_type_codes();

        $display("summary: %0d frames, %0d bytes at rate, %0d channel items checked",
                 frames_sent, bytes_taken, results_seen);
        $display("covered reset and extreme scaling, dropped frames, random traffic, equal codes");
        if (mismatches == 0 && pending_channels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
